[rtl/rfid_frame_parser_slot_store_assert.svh]
// Assertion macros shared by the frame parser RTL.
`ifndef RFID_FRAME_PARSER_SLOT_STORE_ASSERT_SVH
`define RFID_FRAME_PARSER_SLOT_STORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define RFPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define RFPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define RFPS_ASSERT(lbl, prop, msg)
`define RFPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

[rtl/rfps_pkg.sv]
`default_nettype none

package rfps_pkg;

    // Default geometry of a frame and of the slot table
    localparam int FRAME_LEN_DEF = 22;
    localparam int ID_OFFSET_DEF = 15;
    localparam int NUM_SLOTS_DEF = 9;

    // Fixed field widths
    localparam int BYTE_W = 8;
    localparam int DIAL_W = 4;
    localparam int SLOT_W = 4;
    localparam int MASK_W = 9;

    // Reset value of the header byte register
    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'h04;

    // Write request from the parser into the slot table
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] id;
    } slot_wr_t;

endpackage

`default_nettype wire

[rtl/rfps_slot_store.sv]
`default_nettype none

module rfps_slot_store
    import rfps_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [BYTE_W-1:0] lookup_id,
    output logic                   seen,
    input  wire slot_wr_t          wr,
    output logic [MASK_W-1:0]      occ_mask_next
);

    logic [BYTE_W-1:0] id_tab_reg  [NUM_SLOTS];
    logic [BYTE_W-1:0] id_tab_next [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] occ_reg;
    logic [NUM_SLOTS-1:0] occ_next;

    // Compare the identifier against every entry, occupied or not
    always_comb begin
        seen = 1'b0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (id_tab_reg[s] == lookup_id) begin
                seen = 1'b1;
            end
        end
    end

    // Decode the write slot
    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            id_tab_next[s] = id_tab_reg[s];
            occ_next[s]    = occ_reg[s];
            if (wr.en && (wr.slot == SLOT_W'(s))) begin
                id_tab_next[s] = wr.id;
                occ_next[s]    = 1'b1;
            end
        end
    end

    // Hold table and occupied marks; reset clears both
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                id_tab_reg[s] <= '0;
            end
            occ_reg <= '0;
        end else begin
            id_tab_reg <= id_tab_next;
            occ_reg    <= occ_next;
        end
    end

    // Report occupancy after this cycle's write; slots past the mask drop out
    for (genvar g = 0; g < MASK_W; g++) begin : g_mask
        if (g < NUM_SLOTS) begin : g_used
            assign occ_mask_next[g] = occ_next[g];
        end else begin : g_unused
            assign occ_mask_next[g] = 1'b0;
        end
    end

endmodule

`default_nettype wire

[rtl/rfid_frame_parser_slot_store.sv]
// Serial frame parser with card identifier slot store.
//
// s_ channel: one received byte per item with the current dial position.
// A byte equal to the header register, seen outside a frame, opens a frame
// of FRAME_LEN bytes. The byte that closes the frame is checked against the
// inverted XOR of the bytes before it, and a good frame's identifier (byte
// ID_OFFSET) is stored in the dial's slot if the dial is at most NUM_SLOTS
// and no slot already holds it. m_ channel: one result item per input item.
//
// Throughput is one item per cycle while the receiver does not stall: all
// parsing, the table compares and the slot write sit between the parser
// state registers and the result register.
// If the receiver stalls, the result is held and s_tready drops until it is
// taken; an item is accepted in the same cycle the held result leaves.
// Synchronous reset (aresetn low) closes any open frame, clears the table
// and all occupied marks, drops m_tvalid and sets the header byte to 0x04.
// APB: one register, header_byte, at byte address 0; pready is always high.
`default_nettype none

module rfid_frame_parser_slot_store
    import rfps_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int ID_OFFSET = ID_OFFSET_DEF,
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // APB configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // Input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [11:8] dial_position
    // Result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [3:0] slot_index, [11:4] card_id,
                                        // [20:12] occupied_mask
    output logic             m_tlast,   // frame_done
    output logic [1:0]       m_tuser    // [0] frame_ok, [1] stored_new
);

    `include "rfid_frame_parser_slot_store_assert.svh"

    localparam int CNT_W = $clog2(FRAME_LEN);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(FRAME_LEN - 1);
    localparam logic [CNT_W-1:0] ID_IDX   = CNT_W'(ID_OFFSET);
    localparam bit   ID_IN_FRAME          = (ID_OFFSET < FRAME_LEN);
    localparam logic [DIAL_W:0]  DIAL_MAX = (DIAL_W + 1)'(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] WRAP_SLOT = SLOT_W'(NUM_SLOTS - 1);
    localparam logic REG_HEADER = 1'b0;

    // Configuration
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] header_next;
    logic              cfg_wr;

    // Parser state
    logic              in_frame_reg, in_frame_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] cap_reg, cap_next;

    // Result register
    logic              m_valid_reg, m_valid_next;
    logic              done_reg, done_next;
    logic              ok_reg, ok_next;
    logic              stored_reg, stored_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BYTE_W-1:0] id_reg, id_next;
    logic [MASK_W-1:0] mask_reg, mask_next;

    // Item decode
    logic              s_fire;
    logic [BYTE_W-1:0] rx;
    logic [DIAL_W-1:0] dial;
    logic              last_hit;
    logic              cap_hit;
    logic [BYTE_W-1:0] cap_id;
    logic              frame_ok;
    logic              dial_ok;
    logic [SLOT_W-1:0] target;
    logic              seen;
    slot_wr_t          wr;
    logic [MASK_W-1:0] occ_mask_next;

    assign rx   = s_tdata[7:0];
    assign dial = s_tdata[11:8];

    // APB register access
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_HEADER);
    assign header_next = cfg_wr ? pwdata[BYTE_W-1:0] : header_reg;

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_HEADER) begin
            prdata = {{(32 - BYTE_W){1'b0}}, header_reg};
        end
    end

    // Accept while the result register is empty or being drained
    assign s_tready = !m_valid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;

    // Frame position, identifier capture and checksum
    assign last_hit = in_frame_reg && (cnt_reg == LAST_IDX);
    assign cap_hit  = ID_IN_FRAME && in_frame_reg && (cnt_reg == ID_IDX);
    assign cap_id   = cap_hit ? rx : cap_reg;
    assign frame_ok = last_hit && (~xor_reg == rx);

    // Dial to slot: position 0 wraps to the last slot
    assign dial_ok = ({1'b0, dial} <= DIAL_MAX);
    assign target  = (dial == '0) ? WRAP_SLOT : SLOT_W'(dial - 1'b1);

    assign wr.en   = s_fire && frame_ok && !seen && dial_ok;
    assign wr.slot = target;
    assign wr.id   = cap_id;

    rfps_slot_store #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_slot_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .lookup_id     (cap_id),
        .seen          (seen),
        .wr            (wr),
        .occ_mask_next (occ_mask_next)
    );

    // Advance the parser state on each accepted item
    always_comb begin
        in_frame_next = in_frame_reg;
        cnt_next      = cnt_reg;
        xor_next      = xor_reg;
        cap_next      = cap_reg;
        if (s_fire) begin
            if (in_frame_reg) begin
                cap_next = cap_id;
                if (last_hit) begin
                    in_frame_next = 1'b0;
                    cnt_next      = '0;
                    xor_next      = '0;
                end else begin
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                    xor_next = xor_reg ^ rx;
                end
            end else if (rx == header_reg) begin
                in_frame_next = 1'b1;
                cnt_next      = CNT_W'(1);
                xor_next      = rx;
                cap_next      = '0;
            end
        end
    end

    // Load the result register; hold it while the receiver stalls
    always_comb begin
        m_valid_next = m_valid_reg && !m_tready;
        done_next    = done_reg;
        ok_next      = ok_reg;
        stored_next  = stored_reg;
        slot_next    = slot_reg;
        id_next      = id_reg;
        mask_next    = mask_reg;
        if (s_fire) begin
            m_valid_next = 1'b1;
            done_next    = last_hit;
            ok_next      = frame_ok;
            stored_next  = wr.en;
            slot_next    = wr.en ? target : '0;
            id_next      = last_hit ? cap_id : '0;
            mask_next    = occ_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg   <= HEADER_RESET;
            in_frame_reg <= 1'b0;
            cnt_reg      <= '0;
            xor_reg      <= '0;
            cap_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            header_reg   <= header_next;
            in_frame_reg <= in_frame_next;
            cnt_reg      <= cnt_next;
            xor_reg      <= xor_next;
            cap_reg      <= cap_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        done_reg   <= done_next;
        ok_reg     <= ok_next;
        stored_reg <= stored_next;
        slot_reg   <= slot_next;
        id_reg     <= id_next;
        mask_reg   <= mask_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = done_reg;
    assign m_tuser  = {stored_reg, ok_reg};
    assign m_tdata  = {{(24 - MASK_W - BYTE_W - SLOT_W){1'b0}}, mask_reg, id_reg, slot_reg};

    `RFPS_ASSERT(a_store_needs_ok, m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tlast, "slot stored without a good closed frame")
    `RFPS_ASSERT(a_ok_needs_done, m_tvalid && m_tuser[0] |-> m_tlast, "checksum ok reported on a byte that closed no frame")
    `RFPS_ASSERT(a_idle_count_zero, !in_frame_reg |-> (cnt_reg == '0) && (xor_reg == '0), "byte count or checksum left over outside a frame")
    `RFPS_ASSERT(a_fire_gives_result, s_fire |=> m_tvalid, "accepted item produced no result")
    `RFPS_ASSERT(a_occupancy_grows, 1'b1 |=> ((occ_mask_next & $past(occ_mask_next)) == $past(occ_mask_next)), "occupied mark lost without reset")

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
    import rfps_pkg::*;

    localparam logic [2:0] ADDR_HEADER = 3'd0;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 300;

    // One result item, field by field
    typedef struct packed {
        logic              done;
        logic              ok;
        logic              stored;
        logic [SLOT_W-1:0] slot;
        logic [BYTE_W-1:0] card;
        logic [MASK_W-1:0] mask;
    } frame_result_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [7:0] rx_byte, [11:8] dial_position
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [3:0] slot_index, [11:4] card_id, [20:12] occupied_mask
    logic        m_tlast;   // frame_done
    logic [1:0]  m_tuser;   // [0] frame_ok, [1] stored_new

    rfid_frame_parser_slot_store u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Parser state as the block should hold it
    logic [BYTE_W-1:0] hdr_reg;
    logic              in_frame;
    int                byte_idx;
    logic [BYTE_W-1:0] run_xor;
    logic [BYTE_W-1:0] cap_id;
    logic [BYTE_W-1:0] id_table [NUM_SLOTS_DEF];
    logic [MASK_W-1:0] occ_mask;

    frame_result_t pending_results [$];
    int            mismatches = 0;
    bit            calm = 1'b1;
    int            hold_req = 0;
    int            hold_left = 0;
    int            quiet_cycles = 0;

    // Advance the parser by one byte and return the result it must produce
    function automatic frame_result_t parse_byte(input logic [7:0] b, input logic [3:0] dial);
        frame_result_t r;
        logic          seen;
        int            t;
        r = '0;
        if (in_frame) begin
            if (byte_idx == ID_OFFSET_DEF) cap_id = b;
            byte_idx++;
            if (byte_idx >= FRAME_LEN_DEF) begin
                in_frame = 1'b0;
                byte_idx = 0;
                r.done = 1'b1;
                r.card = cap_id;
                if (~run_xor == b) begin
                    r.ok = 1'b1;
                    seen = 1'b0;
                    for (int s = 0; s < NUM_SLOTS_DEF; s++)
                        if (id_table[s] == cap_id) seen = 1'b1;
                    if (!seen && dial <= NUM_SLOTS_DEF) begin
                        t = (dial == 0) ? NUM_SLOTS_DEF - 1 : dial - 1;
                        id_table[t] = cap_id;
                        occ_mask[t] = 1'b1;
                        r.stored = 1'b1;
                        r.slot = SLOT_W'(t);
                    end
                end
                run_xor = '0;
            end else begin
                run_xor ^= b;
            end
        end else if (b == hdr_reg) begin
            in_frame = 1'b1;
            cap_id = '0;
            run_xor = b;
            byte_idx = 1;
        end
        r.mask = occ_mask;
        return r;
    endfunction

    function automatic logic [3:0] rand_dial();
        return ($urandom_range(9) < 2) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
    endfunction

    // Offer one item, with a random gap ahead of it unless calm
    task automatic push_byte(input logic [7:0] b, input logic [3:0] dial);
        if (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, dial, b};
        do @(negedge aclk); while (!s_tready);
        @(posedge aclk);
        pending_results.push_back(parse_byte(b, dial));
    endtask

    // Build and send one frame; optionally break the checksum or make it equal the header
    task automatic send_frame(input logic [7:0] id, input logic [3:0] dial,
                              input bit corrupt, input bit close_hdr);
        logic [7:0] fb [FRAME_LEN_DEF];
        logic [7:0] acc;
        fb[0] = hdr_reg;
        for (int i = 1; i < FRAME_LEN_DEF - 1; i++) fb[i] = 8'($urandom);
        fb[ID_OFFSET_DEF] = id;
        if (close_hdr) begin
            acc = '0;
            for (int i = 0; i < FRAME_LEN_DEF - 1; i++)
                if (i != 1) acc ^= fb[i];
            fb[1] = ~hdr_reg ^ acc;
        end
        acc = '0;
        for (int i = 0; i < FRAME_LEN_DEF - 1; i++) acc ^= fb[i];
        fb[FRAME_LEN_DEF - 1] = ~acc;
        if (corrupt) fb[FRAME_LEN_DEF - 1] ^= 8'($urandom_range(1, 255));
        for (int i = 0; i < FRAME_LEN_DEF; i++)
            push_byte(fb[i], (i == FRAME_LEN_DEF - 1) ? dial : rand_dial());
    endtask

    // Close any frame left open by noise with random filler bytes
    task automatic flush_frame();
        logic [7:0] b;
        while (in_frame) begin
            b = 8'($urandom);
            push_byte(b, rand_dial());
        end
    endtask

    // Stop offering and wait for every result to come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_header(input logic [7:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ADDR_HEADER;
        pwdata  <= {24'($urandom), value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hdr_reg = value;
        @(posedge aclk);
    endtask

    // Store, duplicate, zero identifier and every dial case
    task automatic test_slot_store();
        send_frame(8'h5A, 4'd1, 1'b0, 1'b0);
        send_frame(8'h5A, 4'd2, 1'b0, 1'b0);
        send_frame(8'h00, 4'd3, 1'b0, 1'b0);
        send_frame(8'hFF, 4'd0, 1'b0, 1'b0);
        send_frame(8'h33, 4'd10, 1'b0, 1'b0);
        send_frame(8'h34, 4'd15, 1'b0, 1'b0);
        send_frame(8'h35, 4'd9, 1'b0, 1'b0);
        send_frame(8'h36, 4'd8, 1'b0, 1'b0);
    endtask

    // Bad checksum, closing byte equal to the header, idle noise extremes
    task automatic test_checksum();
        send_frame(8'h77, 4'd5, 1'b1, 1'b0);
        send_frame(8'h78, 4'd6, 1'b0, 1'b1);
        push_byte(8'h00, 4'd0);
        push_byte(8'hFF, 4'd15);
        send_frame(8'h79, 4'd7, 1'b0, 1'b0);
        send_frame(8'h7A, 4'd4, 1'b0, 1'b1);
    endtask

    // Move the header register through its extremes and a random value
    task automatic test_header_register();
        logic [7:0] values [3];
        logic [7:0] old_hdr;
        values[0] = 8'h00;
        values[1] = 8'hFF;
        values[2] = 8'($urandom);
        for (int v = 0; v < 3; v++) begin
            old_hdr = hdr_reg;
            drain_results();
            write_header(values[v]);
            push_byte(old_hdr, rand_dial());
            flush_frame();
            send_frame(8'($urandom), rand_dial(), 1'b0, 1'b0);
            send_frame(8'($urandom), rand_dial(), 1'b0, 1'b1);
        end
    endtask

    // Mostly well-formed frames with random content, some noise and broken frames
    task automatic test_random_traffic();
        logic [7:0] id;
        logic [7:0] b;
        for (int f = 0; f < 17; f++) begin
            calm = (f < 8);
            if (f > 0 && f % 15 == 0) begin
                drain_results();
                write_header(8'($urandom));
            end
            repeat ($urandom_range(0, 3)) begin
                b = ($urandom_range(9) < 2) ? hdr_reg : 8'($urandom);
                push_byte(b, rand_dial());
            end
            flush_frame();
            id = ($urandom_range(3) == 0) ? id_table[$urandom_range(NUM_SLOTS_DEF - 1)]
                                          : 8'($urandom);
            send_frame(id, rand_dial(), $urandom_range(99) < 15, $urandom_range(99) < 5);
        end
    endtask

    // Hold the receiver off for a long stretch while frames keep coming
    task automatic test_backpressure();
        hold_req = LONG_HOLD;
        repeat (3) send_frame(8'($urandom), rand_dial(), 1'b0, 1'b0);
    endtask

    // Receiver: random stalls, calm stretches and one long hold-off
    always @(posedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || ($urandom_range(99) >= 24);
        end
    end

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0h actual %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result item with the oldest expectation
    always @(negedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result item with no expectation waiting");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("frame_done", want.done, m_tlast);
                check_field("frame_ok", want.ok, m_tuser[0]);
                check_field("stored_new", want.stored, m_tuser[1]);
                check_field("slot_index", want.slot, m_tdata[3:0]);
                check_field("card_id", want.card, m_tdata[11:4]);
                check_field("occupied_mask", want.mask, m_tdata[20:12]);
            end
        end
    end

    // End the run if nothing moves on either side for too long
    always @(negedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        hdr_reg  = HEADER_RESET;
        in_frame = 1'b0;
        byte_idx = 0;
        run_xor  = '0;
        cap_id   = '0;
        occ_mask = '0;
        foreach (id_table[s]) id_table[s] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_slot_store();
        calm = 1'b0;
        test_checksum();
        test_random_traffic();
        test_backpressure();
        test_header_register();
        drain_results();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
